### src/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character constants and the hex digit decoder of the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NUL     = 8'h00;

	// escape state, one-hot
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_marker;
		logic       run_last;
	} out_item_t;

	// all results caused by one input item, slot 0 first
	typedef struct packed {
		logic [1:0]      cnt;
		logic            has_end;
		logic [2:0][7:0] data;
	} bundle_t;

	// front to queue
	typedef struct packed {
		logic    push;
		bundle_t bundle;
	} push_t;

	// queue to back
	typedef struct packed {
		logic    avail;
		bundle_t bundle;
	} head_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h61 + 8'd10);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

### src/upd_stream_if.sv
// ----------------------------------------------------------------------------
// upd_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface upd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw bytes, tracks the escape state and builds the result bundle.
// ----------------------------------------------------------------------------
module upd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	upd_stream_if.sink            raw,
	input  logic                  full,
	output upd_pkg::push_t        wr
);
	upd_pkg::phase_t phase_q, phase_d;
	logic [7:0]      held_q, held_d;
	logic [1:0]      n;
	logic [2:0][7:0] b;
	logic            has_end;
	logic            plain;
	logic            accept;
	upd_pkg::hex_t   hx, hh;
	logic [7:0]      c;

	assign c         = raw.data.in_byte;
	assign raw.ready = !full;
	assign accept    = raw.valid && raw.ready;

	always_comb begin
		n       = 2'd0;
		b       = '0;
		has_end = 1'b0;
		plain   = 1'b0;
		phase_d = phase_q;
		held_d  = held_q;
		hx      = upd_pkg::hex_decode(c);
		hh      = upd_pkg::hex_decode(held_q);
		if (raw.data.string_end) begin
			if (phase_q == upd_pkg::PH_PCT || phase_q == upd_pkg::PH_DIGIT) begin
				b[n] = upd_pkg::CH_PERCENT;
				n    = n + 2'd1;
			end
			if (phase_q == upd_pkg::PH_DIGIT) begin
				b[n] = held_q;
				n    = n + 2'd1;
			end
			b[n]    = upd_pkg::CH_NUL;
			n       = n + 2'd1;
			has_end = 1'b1;
			phase_d = upd_pkg::PH_IDLE;
			held_d  = 8'd0;
		end else begin
			case (phase_q)
				upd_pkg::PH_PCT: begin
					if (hx.ok) begin
						held_d  = c;
						phase_d = upd_pkg::PH_DIGIT;
					end else begin
						phase_d = upd_pkg::PH_IDLE;
						b[n]    = upd_pkg::CH_PERCENT;
						n       = n + 2'd1;
						plain   = 1'b1;
					end
				end
				upd_pkg::PH_DIGIT: begin
					phase_d = upd_pkg::PH_IDLE;
					held_d  = 8'd0;
					if (hx.ok) begin
						b[n] = {hh.val, hx.val};
						n    = n + 2'd1;
					end else begin
						b[n] = upd_pkg::CH_PERCENT;
						n    = n + 2'd1;
						b[n] = held_q;
						n    = n + 2'd1;
						plain = 1'b1;
					end
				end
				default: begin
					phase_d = upd_pkg::PH_IDLE;
					plain   = 1'b1;
				end
			endcase
			// breaking byte handled as with no escape pending
			if (plain) begin
				if (c == upd_pkg::CH_PERCENT) begin
					phase_d = upd_pkg::PH_PCT;
				end else if (c == upd_pkg::CH_PLUS) begin
					b[n] = upd_pkg::CH_SPACE;
					n    = n + 2'd1;
				end else begin
					b[n] = c;
					n    = n + 2'd1;
				end
			end
		end
	end

	assign wr.push           = accept && (n != 2'd0);
	assign wr.bundle.cnt     = n;
	assign wr.bundle.has_end = has_end;
	assign wr.bundle.data    = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_IDLE;
			held_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end
endmodule

### src/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue
// Short queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module upd_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  upd_pkg::push_t wr,
	output logic           full,
	input  logic           pop,
	output upd_pkg::head_t head
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	upd_pkg::bundle_t        slots_q [DEPTH];
	logic [AW-1:0]           wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]           count_q;
	logic                    do_pop;

	assign full        = (count_q == FULL_CNT);
	assign head.avail  = (count_q != '0);
	assign head.bundle = slots_q[rd_ptr_q];
	assign do_pop      = pop && head.avail;

	always_ff @(posedge clk) begin
		if (wr.push) begin
			slots_q[wr_ptr_q] <= wr.bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr.push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !wr.push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

### src/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back
// Unpacks the head bundle into single results through an output register.
// ----------------------------------------------------------------------------
module upd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  upd_pkg::head_t head,
	output logic           pop,
	upd_stream_if.source   decoded
);
	logic [1:0]         slot_q;
	logic               valid_q;
	upd_pkg::out_item_t item_q;
	logic               load;
	logic               last;

	assign load = head.avail && (!valid_q || decoded.ready);
	assign last = (slot_q == head.bundle.cnt - 2'd1);
	assign pop  = load && last;

	assign decoded.valid = valid_q;
	assign decoded.data  = item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			item_q.out_byte   <= head.bundle.data[slot_q];
			item_q.end_marker <= last && head.bundle.has_end;
			item_q.run_last   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slot_q  <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				slot_q  <= last ? 2'd0 : slot_q + 2'd1;
			end else if (decoded.ready) begin
				valid_q <= 1'b0;
			end
		end
	end
endmodule

### src/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Form-urlencoded percent decoder, one raw byte per input transfer.
// ----------------------------------------------------------------------------
// raw carries in_byte and string_end; decoded carries out_byte, end_marker
// and run_last, one decoded byte per transfer. '+' becomes a space and a '%'
// with two hex digits becomes one byte; a broken escape passes its '%' and
// held digit through raw. string_end flushes held bytes and then sends an
// end marker result.
// The front takes one raw byte every cycle while the bundle queue has room
// and turns it into zero to three results; the back sends one result per
// cycle from its output register while the receiver is ready. A result
// is held in a queue slot and then in the output register. Sustained rate
// is one input per cycle while inputs average at most one result each and
// output is not stalled; DEPTH bundles absorb items of two or three results.
// When the receiver stalls, the output register holds its item and the
// queue fills, after which raw.ready drops. Reset empties the queue and the
// output register and clears the escape state.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	upd_stream_if.sink   raw,
	upd_stream_if.source decoded
);
	upd_pkg::push_t wr;
	upd_pkg::head_t head;
	logic           full;
	logic           pop;

	upd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.full   (full),
		.wr     (wr)
	);

	upd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	upd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.decoded (decoded)
	);
endmodule

### src/upd_checker.sv
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks on the decoder output stream.
// ----------------------------------------------------------------------------
module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       end_marker,
	input logic       run_last
);
	logic [1:0] run_cnt_q;
	logic       out_xfer;

	assign out_xfer = out_valid && out_ready;

	// results of the current input item sent so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= 2'd0;
		end else if (out_xfer) begin
			run_cnt_q <= run_last ? 2'd0 : run_cnt_q + 2'd1;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("decoded.valid dropped without a transfer");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(end_marker)
			&& $stable(run_last))
		else $error("decoded payload changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && end_marker |-> run_last && (out_byte == 8'd0))
		else $error("end marker not the zero last result of its item");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && (run_cnt_q == 2'd2) |-> run_last)
		else $error("more than three results for one input item");
endmodule

bind url_percent_decoder upd_checker u_upd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (decoded.valid),
	.out_ready  (decoded.ready),
	.out_byte   (decoded.data.out_byte),
	.end_marker (decoded.data.end_marker),
	.run_last   (decoded.data.run_last)
);
